// ----- hdl/look_elevator_controller_top_defines.svh -----
// assertion macros for the look elevator controller
`ifndef LOOK_ELEVATOR_CONTROLLER_TOP_DEFINES_SVH
`define LOOK_ELEVATOR_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lec_pkg.sv -----
// types and constants shared by the look elevator controller
`default_nettype none

package lec_pkg;

    // door ramp phases, codes match the door_state field
    typedef enum logic [1:0] {
        PH_CLOSED  = 2'd0,
        PH_OPENING = 2'd1,
        PH_OPEN    = 2'd2,
        PH_CLOSING = 2'd3
    } door_phase_t;

    // configuration register indexes
    localparam logic [1:0] CFG_TRAVEL_IDX = 2'd0;
    localparam logic [1:0] CFG_DOOR_IDX   = 2'd1;
    localparam logic [1:0] CFG_HOLD_IDX   = 2'd2;

    // register reset values
    localparam logic [11:0] TRAVEL_RESET = 12'd250;
    localparam logic [11:0] DOOR_RESET   = 12'd1000;
    localparam logic [15:0] HOLD_RESET   = 16'd375;

    typedef struct packed {
        logic       call_valid;
        logic [2:0] call_floor;
        logic       open_press;
        logic       close_press;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  floor_now;
        logic        car_moving;
        logic        going_up;
        logic [1:0]  door_state;
        logic [11:0] door_level;
        logic [14:0] car_level;
        logic [7:0]  pending;
        logic        arrived;
    } out_word_t;

endpackage

`default_nettype wire

// ----- hdl/look_elevator_controller_top.sv -----
// look elevator controller: tick-driven car, door ramp and look scheduling
//
// usage
//   s_ channel: one word per tick carrying a floor call and the open and
//   close buttons. m_ channel: one result word per input word, giving the
//   car floor, motion, scan direction, door phase and level, car height,
//   pending request mask and an arrival flag.
//   cfg port: cfg_wen writes cfg_wdata into register cfg_idx
//   (0 travel_ticks, 1 door_ticks, 2 hold_ticks, 3 ignored); write only
//   while no word is in flight.
// timing
//   a word sits in the input register, the whole tick update runs
//   combinationally between that register and the result register:
//   the s_ word passes the input register, then the result register,
//   before m_valid rises; throughput one word per cycle while m_ready is high.
//   the critical path is the 3x12 target multiply, the car position
//   compare and the look priority encode.
// reset
//   aresetn (synchronous, active low) empties both stages, holds s_ready
//   low, restores the register defaults and parks the car at its home
//   floor, doors closed.
// stalls
//   when m_ready is low the result word holds, and one more input word is
//   still taken into the input register before s_ready drops.
`default_nettype none

`include "look_elevator_controller_top_defines.svh"

module look_elevator_controller_top #(
    parameter int FLOORS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input words
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lec_pkg::in_word_t s_word,
    // result words
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lec_pkg::out_word_t     m_word,
    // configuration writes
    input  wire logic              cfg_wen,
    input  wire logic [1:0]        cfg_idx,
    input  wire logic [15:0]       cfg_wdata
);

    import lec_pkg::*;

    // build constants derived from the floor count
    localparam int          HOME_FLOOR = (FLOORS > 2) ? 2 : FLOORS - 1;
    localparam logic [2:0]  HOME_IDX   = 3'(HOME_FLOOR);
    localparam logic [14:0] HOME_POS   = 15'(HOME_FLOOR * 250);
    localparam logic [7:0]  FLOOR_MASK = 8'((1 << FLOORS) - 1);
    localparam logic [3:0]  FLOOR_CNT  = 4'(FLOORS);

    // configuration
    logic [11:0] travel_ticks_reg;
    logic [11:0] door_ticks_reg;
    logic [15:0] hold_ticks_reg;

    // pipeline control and payload
    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic        advance;

    // controller state
    logic [7:0]  req_reg,   req_next;
    logic [2:0]  floor_reg, floor_next;
    logic        dir_reg,   dir_next;
    logic        moving_reg, moving_next;
    logic [14:0] pos_reg,   pos_next;
    logic [11:0] door_pos_reg, door_pos_next;
    door_phase_t phase_reg, phase_next;
    logic [15:0] hold_reg,  hold_next;
    logic        ext_reg,   ext_next;
    logic        arrived_next;

    // datapath helpers
    logic [11:0] travel_eff;
    logic [11:0] door_eff;
    logic [14:0] target;
    logic [12:0] door_sum;
    logic [7:0]  above_mask;
    logic [7:0]  below_mask;
    logic [7:0]  above_req;
    logic [7:0]  below_req;

    // lowest set bit index
    function automatic logic [2:0] lowest_set(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // highest set bit index
    function automatic logic [2:0] highest_set(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // a stage moves forward when it holds a word and the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = aresetn && (!in_valid_reg || advance);
    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    // zero register values act as one
    assign travel_eff = (travel_ticks_reg == 12'd0) ? 12'd1 : travel_ticks_reg;
    assign door_eff   = (door_ticks_reg == 12'd0) ? 12'd1 : door_ticks_reg;

    // car height of the target floor
    assign target = 15'(floor_reg) * 15'(travel_eff);

    // floors above and below the current one
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            above_mask[i] = (3'(i) > floor_reg);
            below_mask[i] = (3'(i) < floor_reg);
        end
    end

    // one tick of the controller
    always_comb begin
        req_next      = req_reg;
        floor_next    = floor_reg;
        dir_next      = dir_reg;
        moving_next   = moving_reg;
        pos_next      = pos_reg;
        door_pos_next = door_pos_reg;
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        ext_next      = ext_reg;
        arrived_next  = 1'b0;
        door_sum      = {1'b0, door_pos_reg} + 13'd1;

        // car motion and arrival
        if (moving_reg) begin
            if (pos_reg == target) begin
                moving_next          = 1'b0;
                arrived_next         = 1'b1;
                req_next[floor_reg]  = 1'b0;
                phase_next           = PH_OPENING;
            end else if (pos_reg < target) begin
                pos_next = pos_reg + 15'd1;
            end else begin
                pos_next = pos_reg - 15'd1;
            end
        end

        // door ramp
        if (phase_next == PH_OPENING) begin
            if (door_sum >= {1'b0, door_eff}) begin
                door_pos_next = door_eff;
                phase_next    = PH_OPEN;
                hold_next     = 16'd0;
                ext_next      = 1'b0;
            end else begin
                door_pos_next = door_sum[11:0];
            end
        end else if (phase_next == PH_CLOSING) begin
            if (door_pos_next != 12'd0) begin
                door_pos_next = door_pos_next - 12'd1;
            end
            if (door_pos_next == 12'd0) begin
                phase_next = PH_CLOSED;
            end
        end

        // automatic close after the hold time
        if (phase_next == PH_OPEN) begin
            if (hold_next >= hold_ticks_reg) begin
                phase_next = PH_CLOSING;
            end else if (hold_next != 16'hFFFF) begin
                hold_next = hold_next + 16'd1;
            end
        end

        // look scheduling, reverse when nothing lies ahead
        above_req = req_next & above_mask;
        below_req = req_next & below_mask;
        if (!moving_next && phase_next == PH_CLOSED) begin
            if (dir_reg) begin
                if (above_req != 8'd0) begin
                    floor_next  = lowest_set(above_req);
                    moving_next = 1'b1;
                end else begin
                    dir_next = 1'b0;
                    if (below_req != 8'd0) begin
                        floor_next  = highest_set(below_req);
                        moving_next = 1'b1;
                    end
                end
            end else begin
                if (below_req != 8'd0) begin
                    floor_next  = highest_set(below_req);
                    moving_next = 1'b1;
                end else begin
                    dir_next = 1'b1;
                    if (above_req != 8'd0) begin
                        floor_next  = lowest_set(above_req);
                        moving_next = 1'b1;
                    end
                end
            end
        end

        // floor call, then open, then close
        if (in_word_reg.call_valid && ({1'b0, in_word_reg.call_floor} < FLOOR_CNT)) begin
            req_next[in_word_reg.call_floor] = 1'b1;
        end
        if (in_word_reg.open_press && phase_next == PH_OPEN && !ext_next) begin
            hold_next = 16'd0;
            ext_next  = 1'b1;
        end
        if (in_word_reg.close_press && phase_next == PH_OPEN) begin
            phase_next = PH_CLOSING;
        end

        req_next = req_next & FLOOR_MASK;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            travel_ticks_reg <= TRAVEL_RESET;
            door_ticks_reg   <= DOOR_RESET;
            hold_ticks_reg   <= HOLD_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_idx)
                CFG_TRAVEL_IDX: travel_ticks_reg <= cfg_wdata[11:0];
                CFG_DOOR_IDX:   door_ticks_reg   <= cfg_wdata[11:0];
                CFG_HOLD_IDX:   hold_ticks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_word_reg.floor_now  <= floor_next;
            out_word_reg.car_moving <= moving_next;
            out_word_reg.going_up   <= dir_next;
            out_word_reg.door_state <= 2'(phase_next);
            out_word_reg.door_level <= door_pos_next;
            out_word_reg.car_level  <= pos_next;
            out_word_reg.pending    <= req_next;
            out_word_reg.arrived    <= arrived_next;
        end
    end

    // controller state, one tick per forwarded word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg      <= 8'd0;
            floor_reg    <= HOME_IDX;
            dir_reg      <= 1'b1;
            moving_reg   <= 1'b0;
            pos_reg      <= HOME_POS;
            door_pos_reg <= 12'd0;
            phase_reg    <= PH_CLOSED;
            hold_reg     <= 16'd0;
            ext_reg      <= 1'b0;
        end else if (advance) begin
            req_reg      <= req_next;
            floor_reg    <= floor_next;
            dir_reg      <= dir_next;
            moving_reg   <= moving_next;
            pos_reg      <= pos_next;
            door_pos_reg <= door_pos_next;
            phase_reg    <= phase_next;
            hold_reg     <= hold_next;
            ext_reg      <= ext_next;
        end
    end

    // the car never travels with the doors anywhere but shut
    `LEC_ASSERT_NOW(a_move_doors_shut, aclk, aresetn, moving_reg,
                    phase_reg == PH_CLOSED, "car moving with doors not closed")
    // an arrival word never reports the car still in motion
    `LEC_ASSERT_NOW(a_arrive_stopped, aclk, aresetn, out_valid_reg && out_word_reg.arrived,
                    !out_word_reg.car_moving, "arrival reported while moving")
    // a forwarded word always lands in the result slot
    `LEC_ASSERT_NEXT(a_advance_fills, aclk, aresetn, advance, out_valid_reg,
                     "result slot empty after advance")

endmodule

`default_nettype wire
